@@ sv/dlt_pkg.sv @@
// dlt_pkg: shared types and constants for the device liveness table
// no dependencies; used by dlt_slot_unit and device_liveness_table
package dlt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int OPC_W  = 2;
    localparam int ADDR_W = 16;
    localparam int KEYIN_W = 64;
    localparam int LEN_W  = 4;
    localparam int CNT_W  = 8;
    localparam int BYTE_W = 8;

    localparam logic [OPC_W-1:0] OP_JOIN      = 2'd0;
    localparam logic [OPC_W-1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [OPC_W-1:0] OP_TICK      = 2'd2;

    localparam logic [CNT_W-1:0] RELOAD_RST = 8'd3;

    localparam logic [BYTE_W-1:0] HDR_KNOWN    = 8'hff;
    localparam logic [BYTE_W-1:0] HDR_OTHER    = 8'hfc;
    localparam logic [BYTE_W-1:0] CLASS_SWITCH = 8'h01;
    localparam logic [BYTE_W-1:0] CLASS_SENSOR = 8'h02;
    localparam logic [BYTE_W-1:0] JOIN_SWITCH  = 8'h13;
    localparam logic [BYTE_W-1:0] JOIN_SENSOR  = 8'h14;
    localparam logic [BYTE_W-1:0] JOIN_OTHER   = 8'h10;
    localparam logic [BYTE_W-1:0] OFF_SWITCH   = 8'h23;
    localparam logic [BYTE_W-1:0] OFF_SENSOR   = 8'h24;
    localparam logic [BYTE_W-1:0] OFF_OTHER    = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_JOIN_WR,
        ST_FLUSH
    } state_t;

    // result of the shared compare unit for the slot under test
    typedef struct packed {
        logic              key_hit;
        logic              addr_hit;
        logic              expire;
        logic [CNT_W-1:0]  cnt_next;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] code;
    } slot_status_t;

endpackage

@@ sv/dlt_entry_ram.sv @@
// dlt_entry_ram: slot storage (address, key, length, countdown), one write
// and one registered read port; depends on nothing
module dlt_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 100
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/dlt_slot_unit.sv @@
// dlt_slot_unit: shared compare and countdown unit applied to one slot per step
// depends on dlt_pkg
module dlt_slot_unit #(
    parameter int KEY_BYTES = dlt_pkg::KEY_BYTES_DEF
) (
    input  logic [KEY_BYTES*8-1:0]       slot_key,
    input  logic [dlt_pkg::LEN_W-1:0]    slot_len,
    input  logic [dlt_pkg::ADDR_W-1:0]   slot_addr,
    input  logic [dlt_pkg::CNT_W-1:0]    slot_cnt,
    input  logic [KEY_BYTES*8-1:0]       req_key,
    input  logic [dlt_pkg::LEN_W-1:0]    req_len,
    input  logic [dlt_pkg::ADDR_W-1:0]   req_addr,
    input  logic [dlt_pkg::BYTE_W-1:0]   first_byte,
    input  logic                         online,
    output dlt_pkg::slot_status_t        status
);

    always_comb begin
        status.key_hit  = (slot_len == req_len) && (slot_key == req_key);
        status.addr_hit = (slot_addr == req_addr);
        // saturating decrement, zero after the tick means offline
        status.cnt_next = (slot_cnt == '0) ? '0 : slot_cnt - dlt_pkg::CNT_W'(1);
        status.expire   = (status.cnt_next == '0);

        if (first_byte == dlt_pkg::CLASS_SWITCH) begin
            status.header = dlt_pkg::HDR_KNOWN;
            status.code   = online ? dlt_pkg::JOIN_SWITCH : dlt_pkg::OFF_SWITCH;
        end else if (first_byte == dlt_pkg::CLASS_SENSOR) begin
            status.header = dlt_pkg::HDR_KNOWN;
            status.code   = online ? dlt_pkg::JOIN_SENSOR : dlt_pkg::OFF_SENSOR;
        end else begin
            status.header = dlt_pkg::HDR_OTHER;
            status.code   = online ? dlt_pkg::JOIN_OTHER : dlt_pkg::OFF_OTHER;
        end
    end

endmodule

@@ sv/device_liveness_table.sv @@
// device_liveness_table: table of joined devices with heartbeat countdowns
//
// Requests come in on s_valid/s_ready with opcode, short address, key and key
// length: join (0), heartbeat (1), tick (2); opcode 3 is taken and dropped.
// Reports leave on m_valid/m_ready, one per join and one per device that a
// tick takes offline, m_last set on the final report of a request.
// The user writes heartbeat_reload through cfg_wr_en/cfg_wr_data only while
// idle; the block does not enforce this. Joins, heartbeats and ticks walk the
// slots through one shared compare unit, each slot in READ (registered memory
// read), then CHECK (check, write back); a heartbeat ends at its first match.
// s_ready is high only between requests. One report sits in the output
// register and one more is held pending during a tick; when the receiver
// stalls, the walk pauses at the next expiring slot until a register frees.
// Reset clears all slot valid bits, loads heartbeat_reload with 3 and drops
// any report in flight; slot contents are only read once written by a join.
// Depends on dlt_pkg, dlt_entry_ram and dlt_slot_unit.
module device_liveness_table #(
    parameter int TABLE_DEPTH = dlt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = dlt_pkg::KEY_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dlt_pkg::OPC_W-1:0]     s_opcode,
    input  logic [dlt_pkg::ADDR_W-1:0]    s_short_addr,
    input  logic [dlt_pkg::KEYIN_W-1:0]   s_device_key,
    input  logic [dlt_pkg::LEN_W-1:0]     s_key_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dlt_pkg::BYTE_W-1:0]    m_header_byte,
    output logic [dlt_pkg::BYTE_W-1:0]    m_code_byte,
    output logic [dlt_pkg::ADDR_W-1:0]    m_device_addr,
    output logic                          m_table_full,
    output logic                          m_last,
    input  logic                          cfg_wr_en,
    input  logic [dlt_pkg::CNT_W-1:0]     cfg_wr_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int KEY_W   = KEY_BYTES * 8;
    localparam int CNT_LO  = 0;
    localparam int LEN_LO  = CNT_LO + dlt_pkg::CNT_W;
    localparam int KEY_LO  = LEN_LO + dlt_pkg::LEN_W;
    localparam int ADDR_LO = KEY_LO + KEY_W;
    localparam int ENTRY_W = ADDR_LO + dlt_pkg::ADDR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [dlt_pkg::LEN_W-1:0] MAX_LEN = dlt_pkg::LEN_W'(KEY_BYTES);

    // control state
    dlt_pkg::state_t          state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0]   valid_reg, valid_next;
    logic                     hit_reg, hit_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic                     m_valid_reg, m_valid_next;
    logic [dlt_pkg::CNT_W-1:0] reload_reg, reload_next;

    // request and report payload
    logic [dlt_pkg::OPC_W-1:0]  op_reg, op_next;
    logic [dlt_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [KEY_W-1:0]           key_reg, key_next;
    logic [dlt_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [dlt_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [dlt_pkg::BYTE_W-1:0] pend_hdr_reg, pend_hdr_next;
    logic [dlt_pkg::BYTE_W-1:0] pend_code_reg, pend_code_next;
    logic [dlt_pkg::BYTE_W-1:0] m_hdr_reg, m_hdr_next;
    logic [dlt_pkg::BYTE_W-1:0] m_code_reg, m_code_next;
    logic [dlt_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic                       m_full_reg, m_full_next;
    logic                       m_last_reg, m_last_next;

    // memory and compare unit hookup
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [ENTRY_W-1:0]         wr_data;
    logic                       rd_en;
    logic [ENTRY_W-1:0]         rd_data;
    logic [dlt_pkg::ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]           rd_key;
    logic [dlt_pkg::LEN_W-1:0]  rd_len;
    logic [dlt_pkg::CNT_W-1:0]  rd_cnt;
    logic [dlt_pkg::BYTE_W-1:0] first_byte;
    logic                       online;
    dlt_pkg::slot_status_t      status;

    logic                       out_free;
    logic                       slot_live;
    logic                       last_slot;
    logic [dlt_pkg::LEN_W-1:0]  len_clamp;
    logic [KEY_W-1:0]           key_masked;

    assign rd_addr = rd_data[ADDR_LO +: dlt_pkg::ADDR_W];
    assign rd_key  = rd_data[KEY_LO +: KEY_W];
    assign rd_len  = rd_data[LEN_LO +: dlt_pkg::LEN_W];
    assign rd_cnt  = rd_data[CNT_LO +: dlt_pkg::CNT_W];

    assign first_byte = (op_reg == dlt_pkg::OP_TICK) ? rd_key[7:0] : key_reg[7:0];
    assign online     = (op_reg != dlt_pkg::OP_TICK);

    dlt_entry_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (idx_reg),
        .rd_data (rd_data)
    );

    dlt_slot_unit #(
        .KEY_BYTES (KEY_BYTES)
    ) u_slot (
        .slot_key   (rd_key),
        .slot_len   (rd_len),
        .slot_addr  (rd_addr),
        .slot_cnt   (rd_cnt),
        .req_key    (key_reg),
        .req_len    (len_reg),
        .req_addr   (addr_reg),
        .first_byte (first_byte),
        .online     (online),
        .status     (status)
    );

    // clamp length and zero the key bytes past it
    always_comb begin
        len_clamp = (s_key_length > MAX_LEN) ? MAX_LEN : s_key_length;
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_masked[b*8 +: 8] = (dlt_pkg::LEN_W'(b) < len_clamp) ?
                                   s_device_key[b*8 +: 8] : 8'h00;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign slot_live = valid_reg[idx_reg];
    assign last_slot = (idx_reg == LAST_IDX);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_hdr_next   = pend_hdr_reg;
        pend_code_next  = pend_code_reg;
        reload_next     = cfg_wr_en ? cfg_wr_data : reload_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_hdr_next      = m_hdr_reg;
        m_code_next     = m_code_reg;
        m_addr_next     = m_addr_reg;
        m_full_next     = m_full_reg;
        m_last_next     = m_last_reg;
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_data         = rd_data;

        case (state_reg)
            dlt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next         = s_opcode;
                    addr_next       = s_short_addr;
                    key_next        = key_masked;
                    len_next        = len_clamp;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if (s_opcode == dlt_pkg::OP_JOIN || s_opcode == dlt_pkg::OP_HEARTBEAT
                        || s_opcode == dlt_pkg::OP_TICK) begin
                        state_next = dlt_pkg::ST_READ;
                    end
                end
            end
            dlt_pkg::ST_READ: begin
                rd_en      = 1'b1;
                state_next = dlt_pkg::ST_CHECK;
            end
            dlt_pkg::ST_CHECK: begin
                case (op_reg)
                    dlt_pkg::OP_JOIN: begin
                        if (slot_live && status.key_hit) begin
                            // known device: only the address changes
                            wr_en      = 1'b1;
                            wr_data    = {addr_reg, rd_key, rd_len, rd_cnt};
                            hit_next   = 1'b1;
                            state_next = dlt_pkg::ST_JOIN_WR;
                        end else begin
                            if (!slot_live && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            if (last_slot) begin
                                state_next = dlt_pkg::ST_JOIN_WR;
                            end else begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = dlt_pkg::ST_READ;
                            end
                        end
                    end
                    dlt_pkg::OP_HEARTBEAT: begin
                        if (slot_live && status.addr_hit) begin
                            wr_en      = 1'b1;
                            wr_data    = {rd_addr, rd_key, rd_len, reload_reg};
                            state_next = dlt_pkg::ST_IDLE;
                        end else if (last_slot) begin
                            state_next = dlt_pkg::ST_IDLE;
                        end else begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = dlt_pkg::ST_READ;
                        end
                    end
                    dlt_pkg::OP_TICK: begin
                        // hold an expiring slot when both report registers are busy
                        if (!(slot_live && status.expire && pend_valid_reg && !out_free)) begin
                            if (slot_live) begin
                                wr_en   = 1'b1;
                                wr_data = {rd_addr, rd_key, rd_len, status.cnt_next};
                                if (status.expire) begin
                                    valid_next[idx_reg] = 1'b0;
                                    if (pend_valid_reg) begin
                                        m_valid_next = 1'b1;
                                        m_hdr_next   = pend_hdr_reg;
                                        m_code_next  = pend_code_reg;
                                        m_addr_next  = pend_addr_reg;
                                        m_full_next  = 1'b0;
                                        m_last_next  = 1'b0;
                                    end
                                    pend_valid_next = 1'b1;
                                    pend_addr_next  = rd_addr;
                                    pend_hdr_next   = status.header;
                                    pend_code_next  = status.code;
                                end
                            end
                            if (last_slot) begin
                                state_next = pend_valid_next ? dlt_pkg::ST_FLUSH
                                                             : dlt_pkg::ST_IDLE;
                            end else begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = dlt_pkg::ST_READ;
                            end
                        end
                    end
                    default: begin
                        state_next = dlt_pkg::ST_IDLE;
                    end
                endcase
            end
            dlt_pkg::ST_JOIN_WR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hdr_next   = status.header;
                    m_code_next  = status.code;
                    m_addr_next  = addr_reg;
                    m_full_next  = !hit_reg && !free_found_reg;
                    m_last_next  = 1'b1;
                    if (!hit_reg && free_found_reg) begin
                        wr_en                    = 1'b1;
                        wr_idx                   = free_idx_reg;
                        wr_data                  = {addr_reg, key_reg, len_reg, reload_reg};
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    state_next = dlt_pkg::ST_IDLE;
                end
            end
            dlt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_hdr_next      = pend_hdr_reg;
                    m_code_next     = pend_code_reg;
                    m_addr_next     = pend_addr_reg;
                    m_full_next     = 1'b0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = dlt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dlt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dlt_pkg::ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            reload_reg     <= dlt_pkg::RELOAD_RST;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            reload_reg     <= reload_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        pend_addr_reg <= pend_addr_next;
        pend_hdr_reg  <= pend_hdr_next;
        pend_code_reg <= pend_code_next;
        m_hdr_reg     <= m_hdr_next;
        m_code_reg    <= m_code_next;
        m_addr_reg    <= m_addr_next;
        m_full_reg    <= m_full_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_header_byte = m_hdr_reg;
    assign m_code_byte   = m_code_reg;
    assign m_device_addr = m_addr_reg;
    assign m_table_full  = m_full_reg;
    assign m_last        = m_last_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for device_liveness_table, with a slot-table predictor,
// a request driver and a report monitor; random stalls on both channels
// depends on dlt_pkg and device_liveness_table
module tb;

    localparam int SLOTS        = dlt_pkg::TABLE_DEPTH_DEF;
    localparam int KEYB         = dlt_pkg::KEY_BYTES_DEF;
    localparam int SETTLE       = 50;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL         = 24;
    localparam int PHASE_ITEMS  = 52;
    localparam int MAX_LOGGED   = 20;
    localparam logic [dlt_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [dlt_pkg::OPC_W-1:0]   opcode;
        logic [dlt_pkg::ADDR_W-1:0]  addr;
        logic [dlt_pkg::KEYIN_W-1:0] key;
        logic [dlt_pkg::LEN_W-1:0]   len;
    } request_t;

    typedef struct packed {
        logic [dlt_pkg::BYTE_W-1:0] header;
        logic [dlt_pkg::BYTE_W-1:0] code;
        logic [dlt_pkg::ADDR_W-1:0] addr;
        logic                       full;
        logic                       last;
    } report_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [dlt_pkg::OPC_W-1:0]     s_opcode = '0;
    logic [dlt_pkg::ADDR_W-1:0]    s_short_addr = '0;
    logic [dlt_pkg::KEYIN_W-1:0]   s_device_key = '0;
    logic [dlt_pkg::LEN_W-1:0]     s_key_length = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [dlt_pkg::BYTE_W-1:0]    m_header_byte;
    logic [dlt_pkg::BYTE_W-1:0]    m_code_byte;
    logic [dlt_pkg::ADDR_W-1:0]    m_device_addr;
    logic                          m_table_full;
    logic                          m_last;
    logic                          cfg_wr_en = 1'b0;
    logic [dlt_pkg::CNT_W-1:0]     cfg_wr_data = '0;

    device_liveness_table i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_short_addr  (s_short_addr),
        .s_device_key  (s_device_key),
        .s_key_length  (s_key_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_byte (m_header_byte),
        .m_code_byte   (m_code_byte),
        .m_device_addr (m_device_addr),
        .m_table_full  (m_table_full),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // predicted device table
    bit                        dev_live [SLOTS];
    logic [15:0]               dev_addr [SLOTS];
    logic [63:0]               dev_key [SLOTS];
    logic [3:0]                dev_len [SLOTS];
    logic [7:0]                dev_count [SLOTS];
    logic [dlt_pkg::CNT_W-1:0] reload_value = dlt_pkg::RELOAD_RST;

    request_t requests_pending[$];
    report_t  reports_due[$];
    report_t  due_head;
    request_t next_req;

    // stimulus pool of known devices
    logic [63:0] pool_key [POOL];
    logic [3:0]  pool_len [POOL];
    logic [15:0] pool_addr [POOL];

    int  failures = 0;
    int  requests_taken = 0;
    int  reports_checked = 0;
    int  offline_due = 0;
    int  refused_joins = 0;
    int  quiet = 0;
    int  tx_idle_pct = 8;
    int  rx_idle_pct = 60;
    int  hold_left = 0;
    bit  hold_go = 1'b0;
    bit  hold_seen = 1'b0;
    bit  s_took = 1'b0;
    logic [dlt_pkg::CNT_W-1:0] last_reload;

    function automatic logic [63:0] key_bytes_mask(logic [3:0] len);
        if (len >= KEYB)
            return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic report_t device_report(logic [63:0] key, bit online,
                                              logic [15:0] addr, bit refused);
        report_t r;
        r.header = dlt_pkg::HDR_KNOWN;
        r.addr   = addr;
        r.full   = refused;
        r.last   = 1'b0;
        if (key[7:0] == dlt_pkg::CLASS_SWITCH) begin
            r.code = online ? dlt_pkg::JOIN_SWITCH : dlt_pkg::OFF_SWITCH;
        end else if (key[7:0] == dlt_pkg::CLASS_SENSOR) begin
            r.code = online ? dlt_pkg::JOIN_SENSOR : dlt_pkg::OFF_SENSOR;
        end else begin
            r.header = dlt_pkg::HDR_OTHER;
            r.code   = online ? dlt_pkg::JOIN_OTHER : dlt_pkg::OFF_OTHER;
        end
        return r;
    endfunction

    // update the predicted table with one accepted request, queue its reports
    task automatic apply_request(request_t q);
        int          hit;
        int          spare;
        logic [3:0]  len;
        logic [63:0] key;
        report_t     r;
        report_t     gone[$];
        bit          done;
        len = (q.len > KEYB) ? 4'(KEYB) : q.len;
        key = q.key & key_bytes_mask(len);
        case (q.opcode)
            dlt_pkg::OP_JOIN: begin
                hit = -1;
                spare = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (dev_live[i]) begin
                        if (hit < 0 && dev_len[i] == len && dev_key[i] == key)
                            hit = i;
                    end else if (spare < 0) begin
                        spare = i;
                    end
                end
                if (hit >= 0) begin
                    dev_addr[hit] = q.addr;
                end else if (spare >= 0) begin
                    dev_live[spare]  = 1'b1;
                    dev_addr[spare]  = q.addr;
                    dev_key[spare]   = key;
                    dev_len[spare]   = len;
                    dev_count[spare] = reload_value;
                end else begin
                    refused_joins++;
                end
                r = device_report(key, 1'b1, q.addr, hit < 0 && spare < 0);
                r.last = 1'b1;
                reports_due.push_back(r);
            end
            dlt_pkg::OP_HEARTBEAT: begin
                done = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && dev_live[i] && dev_addr[i] == q.addr) begin
                        dev_count[i] = reload_value;
                        done = 1'b1;
                    end
                end
            end
            dlt_pkg::OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (dev_live[i]) begin
                        if (dev_count[i] != 0)
                            dev_count[i] = dev_count[i] - 8'd1;
                        if (dev_count[i] == 0) begin
                            dev_live[i] = 1'b0;
                            gone.push_back(device_report(dev_key[i], 1'b0,
                                                         dev_addr[i], 1'b0));
                        end
                    end
                end
                if (gone.size() > 0)
                    gone[gone.size() - 1].last = 1'b1;
                offline_due += gone.size();
                foreach (gone[i])
                    reports_due.push_back(gone[i]);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_LOGGED)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // monitor: check reports first, then predict from the request taken at this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    failures++;
                    if (failures <= MAX_LOGGED)
                        $display("%0t: report with none expected, expected nothing, actual %0h",
                                 $time, {m_header_byte, m_code_byte, m_device_addr,
                                         m_table_full, m_last});
                end else begin
                    due_head = reports_due.pop_front();
                    check_field("header_byte", 64'(due_head.header), 64'(m_header_byte));
                    check_field("code_byte", 64'(due_head.code), 64'(m_code_byte));
                    check_field("device_addr", 64'(due_head.addr), 64'(m_device_addr));
                    check_field("table_full", 64'(due_head.full), 64'(m_table_full));
                    check_field("last", 64'(due_head.last), 64'(m_last));
                    reports_checked++;
                end
            end
            if (s_valid && s_ready) begin
                apply_request('{s_opcode, s_short_addr, s_device_key, s_key_length});
                requests_taken++;
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = requests_pending.pop_front();
                s_valid      <= 1'b1;
                s_opcode     <= next_req.opcode;
                s_short_addr <= next_req.addr;
                s_device_key <= next_req.key;
                s_key_length <= next_req.len;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // report receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void push_req(logic [dlt_pkg::OPC_W-1:0] op, logic [15:0] addr,
                                     logic [63:0] key, logic [3:0] len);
        request_t q;
        q.opcode = op;
        q.addr   = addr;
        q.key    = key;
        q.len    = len;
        requests_pending.push_back(q);
    endfunction

    // mostly joins and heartbeats of pooled devices, ticks, and some noise
    function automatic request_t random_request();
        request_t    q;
        int          pick;
        int          idx;
        logic [63:0] mask;
        pick     = $urandom_range(99);
        idx      = $urandom_range(POOL - 1);
        q.key    = {$urandom, $urandom};
        q.len    = 4'($urandom_range(15));
        q.addr   = 16'($urandom);
        q.opcode = OP_UNUSED;
        if (pick < 40) begin
            q.opcode = dlt_pkg::OP_JOIN;
            mask  = key_bytes_mask((pool_len[idx] > KEYB) ? 4'(KEYB) : pool_len[idx]);
            q.key = (q.key & ~mask) | (pool_key[idx] & mask);
            q.len = pool_len[idx];
            if ($urandom_range(3) == 0)
                pool_addr[idx] = 16'($urandom);
            q.addr = pool_addr[idx];
        end else if (pick < 70) begin
            q.opcode = dlt_pkg::OP_HEARTBEAT;
            if ($urandom_range(6) != 0)
                q.addr = pool_addr[idx];
        end else if (pick < 88) begin
            q.opcode = dlt_pkg::OP_TICK;
        end else if (pick < 95) begin
            q.opcode = dlt_pkg::OP_JOIN;
        end
        return q;
    endfunction

    task automatic wait_idle();
        while (requests_pending.size() != 0 || s_valid || reports_due.size() != 0)
            @(posedge aclk);
        // heartbeats and quiet ticks may still be walking the slots
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reload(logic [dlt_pkg::CNT_W-1:0] v);
        @(negedge aclk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        reload_value = v;
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++)
            dev_live[i] = 1'b0;
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = {$urandom, $urandom};
            case ($urandom_range(2))
                0: pool_key[i][7:0] = dlt_pkg::CLASS_SWITCH;
                1: pool_key[i][7:0] = dlt_pkg::CLASS_SENSOR;
                default: begin
                end
            endcase
            pool_len[i]  = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8));
            pool_addr[i] = 16'($urandom);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: classes, key length edges, rejoin, full table, expiry burst
        push_req(dlt_pkg::OP_JOIN, 16'h0000, 64'hFFFF_FFFF_FFFF_FF01, 4'd8);
        push_req(dlt_pkg::OP_JOIN, 16'hFFFF, 64'h0123_4567_89AB_CD02, 4'd15);
        push_req(dlt_pkg::OP_JOIN, 16'h1234, 64'hDEAD_BEEF_0000_0001, 4'd0);
        push_req(dlt_pkg::OP_JOIN, 16'h5678, 64'hFFFF_FFFF_FFFF_FF03, 4'd1);
        push_req(dlt_pkg::OP_JOIN, 16'h9ABC, 64'h1111_2222_3333_4403, 4'd1);
        push_req(dlt_pkg::OP_JOIN, 16'h1111, 64'h0, 4'd0);
        for (int i = 0; i < 12; i++)
            push_req(dlt_pkg::OP_JOIN, (i == 5) ? 16'hFFFF : 16'(16'h0100 + i),
                     {48'h0, 8'(i), 8'(i % 3 + 1)}, 4'd2);
        push_req(dlt_pkg::OP_JOIN, 16'hA5A5, 64'h0000_0000_0000_7703, 4'd2);
        push_req(dlt_pkg::OP_JOIN, 16'h8001, 64'hFFFF_FFFF_FFFF_FF01, 4'd8);
        push_req(dlt_pkg::OP_TICK, 16'h0, 64'h0, 4'd0);
        // duplicate address: only the lowest slot is reloaded
        push_req(dlt_pkg::OP_HEARTBEAT, 16'hFFFF, 64'h0, 4'd0);
        push_req(dlt_pkg::OP_HEARTBEAT, 16'h4242, 64'h0, 4'd0);
        push_req(OP_UNUSED, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        push_req(dlt_pkg::OP_TICK, 16'h0, 64'h0, 4'd0);
        push_req(dlt_pkg::OP_TICK, 16'h0, 64'h0, 4'd0);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 8 : (p == 1) ? 60 : 0;
            rx_idle_pct = (p == 0) ? 60 : (p == 1) ? 8 : 0;
            last_reload = (p == 0) ? 8'd1 : (p == 1) ? 8'd255 : 8'($urandom_range(2, 5));
            write_reload(last_reload);
            for (int n = 0; n < PHASE_ITEMS; n++)
                requests_pending.push_back(random_request());
            // long receiver stall so the block backs up onto its request side
            if (p == 2) begin
                @(posedge aclk);
                hold_go = ~hold_go;
            end
            wait_idle();
        end

        if (reports_due.size() != 0)
            failures++;
        $display("tb: %0d requests taken, %0d reports checked (%0d offline, %0d refused joins)",
                 requests_taken, reports_checked, offline_due, refused_joins);
        $display("tb: reload values 3, 1, 255 and %0d, with stalls on both sides and a long hold",
                 last_reload);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dlt_pkg.sv
sv/dlt_entry_ram.sv
sv/dlt_slot_unit.sv
sv/device_liveness_table.sv
verif/tb.sv
